/* hw/rtl/xorshift128_ranged_random_core_assert.svh */
// Assertion macros shared by the ranged xorshift128 core RTL.
// Clock and active-low reset are passed in; no other dependencies.
`ifndef XORSHIFT128_RANGED_RANDOM_CORE_ASSERT_SVH
`define XORSHIFT128_RANGED_RANDOM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define XSR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define XSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define XSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define XSR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/xsr_pkg.sv */
// Types, constants and the xorshift128 step function for the ranged core.
// No dependencies; used by xsr_ctrl, xsr_datapath and the top level.
package xsr_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 2;

	localparam logic [WORD_W-1:0] SEED_A_RST = 32'd123456789;
	localparam logic [WORD_W-1:0] SEED_B_RST = 32'd362436069;
	localparam logic [WORD_W-1:0] SEED_C_RST = 32'd521288629;
	localparam logic [WORD_W-1:0] SEED_D_RST = 32'd88675123;

	localparam logic [IDX_W-1:0] REG_SEED_A = 2'd0;
	localparam logic [IDX_W-1:0] REG_SEED_B = 2'd1;
	localparam logic [IDX_W-1:0] REG_SEED_C = 2'd2;
	localparam logic [IDX_W-1:0] REG_SEED_D = 2'd3;

	localparam logic REQ_DRAW   = 1'b0;
	localparam logic REQ_RESEED = 1'b1;

	localparam int SHL_D = 11;
	localparam int SHR_T = 8;
	localparam int SHR_A = 19;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WARM,
		S_LOAD,
		S_DIV,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RES_HIGH,
		RES_RAW,
		RES_MOD,
		RES_ZERO
	} res_sel_t;

	typedef struct packed {
		logic     load_req;
		logic     seed;
		logic     step;
		logic     div_start;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic req_type;
		logic lo_ge_hi;
		logic width_zero;
	} sts_t;

	// New newest word from the newest (a) and oldest (d) state words.
	function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] t;
		t = d ^ (d << SHL_D);
		t = t ^ (t >> SHR_T);
		return t ^ a ^ (a >> SHR_A);
	endfunction

endpackage

/* hw/rtl/xsr_datapath.sv */
// Datapath: seed registers, generator state, request capture,
// bit-serial remainder unit and result register. Uses xsr_pkg.
`include "xorshift128_ranged_random_core_assert.svh"
module xsr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [xsr_pkg::IDX_W-1:0]  cfg_index,
	input  logic [xsr_pkg::WORD_W-1:0] cfg_wdata,
	input  logic                       in_type,
	input  logic [xsr_pkg::WORD_W-1:0] in_low,
	input  logic [xsr_pkg::WORD_W-1:0] in_high,
	input  xsr_pkg::cmd_t              cmd,
	output xsr_pkg::sts_t              sts,
	output logic [xsr_pkg::WORD_W-1:0] value
);

	logic [xsr_pkg::WORD_W-1:0] seed_a_q, seed_b_q, seed_c_q, seed_d_q;
	logic [xsr_pkg::WORD_W-1:0] gen_a_q, gen_b_q, gen_c_q, gen_d_q;
	logic                       type_q;
	logic [xsr_pkg::WORD_W-1:0] lo_q, hi_q, width_q;
	logic [xsr_pkg::WORD_W-1:0] rem_q, dvd_q, value_q;
	logic [xsr_pkg::WORD_W:0]   trial;
	logic [xsr_pkg::WORD_W:0]   trial_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= xsr_pkg::SEED_A_RST;
			seed_b_q <= xsr_pkg::SEED_B_RST;
			seed_c_q <= xsr_pkg::SEED_C_RST;
			seed_d_q <= xsr_pkg::SEED_D_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xsr_pkg::REG_SEED_A: seed_a_q <= cfg_wdata;
				xsr_pkg::REG_SEED_B: seed_b_q <= cfg_wdata;
				xsr_pkg::REG_SEED_C: seed_c_q <= cfg_wdata;
				xsr_pkg::REG_SEED_D: seed_d_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= xsr_pkg::SEED_A_RST;
			gen_b_q <= xsr_pkg::SEED_B_RST;
			gen_c_q <= xsr_pkg::SEED_C_RST;
			gen_d_q <= xsr_pkg::SEED_D_RST;
		end else if (cmd.seed) begin
			gen_a_q <= seed_a_q;
			gen_b_q <= seed_b_q;
			gen_c_q <= seed_c_q;
			gen_d_q <= seed_d_q;
		end else if (cmd.step) begin
			gen_a_q <= xsr_pkg::xs_next(gen_a_q, gen_d_q);
			gen_b_q <= gen_a_q;
			gen_c_q <= gen_b_q;
			gen_d_q <= gen_c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= in_type;
			lo_q   <= in_low;
			hi_q   <= in_high;
		end
	end

	// Restoring remainder, one dividend bit per beat of the unit
	assign trial     = {rem_q, dvd_q[xsr_pkg::WORD_W-1]};
	assign trial_sub = trial - {1'b0, width_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			width_q <= hi_q - lo_q + xsr_pkg::WORD_W'(1);
			rem_q   <= '0;
			dvd_q   <= gen_a_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_sub[xsr_pkg::WORD_W] ? trial[xsr_pkg::WORD_W-1:0]
			                                    : trial_sub[xsr_pkg::WORD_W-1:0];
			dvd_q <= {dvd_q[xsr_pkg::WORD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				xsr_pkg::RES_HIGH: value_q <= hi_q;
				xsr_pkg::RES_RAW:  value_q <= gen_a_q;
				xsr_pkg::RES_MOD:  value_q <= lo_q + rem_q;
				xsr_pkg::RES_ZERO: value_q <= '0;
			endcase
		end
	end

	assign sts.req_type   = type_q;
	assign sts.lo_ge_hi   = (lo_q >= hi_q);
	assign sts.width_zero = (lo_q == '0) && (hi_q == '1);
	assign value          = value_q;

	`XSR_ASSERT_IMPL(a_rem_below_width, clk, arst_n, $past(cmd.div_step), rem_q < width_q, "remainder not below range width")

endmodule

/* hw/rtl/xsr_ctrl.sv */
// Controller: request sequencing, warm-up and division step counters,
// output valid. Uses xsr_pkg and the assertion macro header.
`include "xorshift128_ranged_random_core_assert.svh"
module xsr_ctrl #(
	parameter int WARMUP_STEPS = 5000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  xsr_pkg::sts_t sts,
	output xsr_pkg::cmd_t cmd
);

	localparam int CNT_W = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
	localparam int DIV_W = $clog2(xsr_pkg::WORD_W);

	xsr_pkg::state_t   state_q, state_d;
	xsr_pkg::res_sel_t res_sel_q, res_sel_d;
	logic [CNT_W-1:0]  warm_cnt_q;
	logic [DIV_W-1:0]  div_cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		res_sel_d = res_sel_q;
		unique case (state_q)
			xsr_pkg::S_IDLE: begin
				if (in_valid) state_d = xsr_pkg::S_DECIDE;
			end
			xsr_pkg::S_DECIDE: begin
				if (sts.req_type == xsr_pkg::REQ_RESEED) begin
					state_d = xsr_pkg::S_WARM;
				end else if (sts.lo_ge_hi) begin
					state_d   = xsr_pkg::S_FIN;
					res_sel_d = xsr_pkg::RES_HIGH;
				end else begin
					state_d = xsr_pkg::S_LOAD;
				end
			end
			xsr_pkg::S_WARM: begin
				if (warm_cnt_q == '0) begin
					state_d   = xsr_pkg::S_FIN;
					res_sel_d = xsr_pkg::RES_ZERO;
				end
			end
			xsr_pkg::S_LOAD: begin
				if (sts.width_zero) begin
					state_d   = xsr_pkg::S_FIN;
					res_sel_d = xsr_pkg::RES_RAW;
				end else begin
					state_d = xsr_pkg::S_DIV;
				end
			end
			xsr_pkg::S_DIV: begin
				if (div_cnt_q == '1) begin
					state_d   = xsr_pkg::S_FIN;
					res_sel_d = xsr_pkg::RES_MOD;
				end
			end
			xsr_pkg::S_FIN: begin
				if (out_free) state_d = xsr_pkg::S_IDLE;
			end
			default: state_d = xsr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.res_sel = res_sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			xsr_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			xsr_pkg::S_DECIDE: begin
				cmd.seed = (sts.req_type == xsr_pkg::REQ_RESEED);
				cmd.step = (sts.req_type == xsr_pkg::REQ_DRAW) && !sts.lo_ge_hi;
			end
			xsr_pkg::S_WARM: cmd.step      = (warm_cnt_q != '0);
			xsr_pkg::S_LOAD: cmd.div_start = !sts.width_zero;
			xsr_pkg::S_DIV:  cmd.div_step  = 1'b1;
			xsr_pkg::S_FIN:  cmd.res_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xsr_pkg::S_IDLE;
			res_sel_q   <= xsr_pkg::RES_ZERO;
			warm_cnt_q  <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
			if (state_q == xsr_pkg::S_DECIDE) begin
				warm_cnt_q <= CNT_W'(WARMUP_STEPS);
			end else if (cmd.step && state_q == xsr_pkg::S_WARM) begin
				warm_cnt_q <= warm_cnt_q - CNT_W'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_W'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`XSR_ASSERT_IMPL(a_load_when_free, clk, arst_n, cmd.res_load, !out_valid_q || out_ready, "result overwrote an untaken beat")
	`XSR_ASSERT_IMPL(a_accept_decide, clk, arst_n, in_valid && in_ready, ##1 state_q == xsr_pkg::S_DECIDE, "accepted beat not decoded")
	`XSR_ASSERT_IMPL(a_div_full_count, clk, arst_n, state_q == xsr_pkg::S_FIN && $past(state_q) == xsr_pkg::S_DIV, $past(div_cnt_q) == '1, "remainder left before all steps")

endmodule

/* hw/rtl/xorshift128_ranged_random_core.sv */
// Top level of the ranged xorshift128 random number core.
// Instantiates xsr_ctrl and xsr_datapath; uses xsr_pkg.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+------------------------------------
//  request  | s_axis_tvalid/tready/tdata/tuser| tdata: range_low, range_high; tuser: req_type
//  result   | m_axis_tvalid/tready/tdata      | tdata: value
//  config   | cfg_we, cfg_index, cfg_wdata    | seed words a..d at index 0..3
//
// One request at a time. A draw over a proper, non-full range runs the 32-step
// bit-serial remainder unit between accept and the next ready. Full-range draws
// return the raw word, low >= high returns range_high, reseeds run WARMUP_STEPS warm-up steps.
// Reset loads the default seeds into both the seed registers and the state.
// A result waits in the output register; the core finishes the next request
// up to its last step while that beat stays untaken.
module xorshift128_ranged_random_core #(
	parameter int WARMUP_STEPS = 5000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [63:0]                s_axis_tdata,  // [31:0] range_low, [63:32] range_high
	input  logic                       s_axis_tuser,  // [0] req_type
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [xsr_pkg::WORD_W-1:0] m_axis_tdata,  // [31:0] value
	input  logic                       cfg_we,
	input  logic [xsr_pkg::IDX_W-1:0]  cfg_index,
	input  logic [xsr_pkg::WORD_W-1:0] cfg_wdata
);

	xsr_pkg::cmd_t cmd;
	xsr_pkg::sts_t sts;

	xsr_ctrl #(
		.WARMUP_STEPS(WARMUP_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	xsr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_type   (s_axis_tuser),
		.in_low    (s_axis_tdata[31:0]),
		.in_high   (s_axis_tdata[63:32]),
		.cmd       (cmd),
		.sts       (sts),
		.value     (m_axis_tdata)
	);

endmodule
